@@ rtl/core/bucketed_hash_table_unit_assert.svh @@
// Assertion macros for the bucketed hash table unit.
`ifndef BUCKETED_HASH_TABLE_UNIT_ASSERT_SVH
`define BUCKETED_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BHT_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BHT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/bht_pkg.sv @@
// Shared types and codes for the bucketed hash table unit.
package bht_pkg;

	localparam int MOD_W = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_FRD   = 7'b0001000,
		S_CHK   = 7'b0010000,
		S_SCAN  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] rem;
	} hash_stat_t;

endpackage

@@ rtl/core/bucketed_hash_table_unit.sv @@
// Bucketed hash table unit: top level with sequencer, fill-count and entry RAMs.
// One operation at a time. After acceptance the key bytes are summed, the sum is
// reduced modulo the bucket count by a bit-serial compare-subtract unit (one step
// per bit of the byte sum, 11 steps at eight key bytes), the bucket fill count is
// read, and then an insert writes one entry while a lookup compares the bucket's
// entries one per cycle in insertion order. The input is ready again in the cycle
// the result word appears, and an operation holds in its last step while an
// earlier result word still waits. After reset the fill counts are cleared one
// bucket per cycle, and no word is taken until every bucket is cleared;
// configuration writes are taken at any time. A bucket count of zero acts as one,
// a count above BUCKETS as BUCKETS, and a key length above KEY_BYTES as KEY_BYTES.
module bucketed_hash_table_unit import bht_pkg::*; #(
	parameter int BUCKETS     = 64,
	parameter int WAYS        = 8,
	parameter int KEY_BYTES   = 8,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,   // bucket_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,    // key_bytes[63:0], key_len[67:64], handle[83:68], pad
	input  logic [0:0]  s_tuser,    // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // found_handle
	output logic [1:0]  m_tuser     // status
);

	localparam int KW   = 8 * KEY_BYTES;
	localparam int HW   = HANDLE_BITS < 16 ? HANDLE_BITS : 16;
	localparam int BW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int AW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int CW   = $clog2(WAYS + 1);
	localparam int MMAX = BUCKETS < 127 ? BUCKETS : 127;

	state_t           state_q;
	logic [BW-1:0]    clr_q;
	logic [6:0]       bc_q;
	logic             out_v_q;
	logic [1:0]       out_status_q;
	logic [15:0]      out_fh_q;

	logic             op_q;
	logic [KW-1:0]    key_q;
	logic [3:0]       len_q;
	logic [HW-1:0]    hdl_q;
	logic [BW-1:0]    bucket_q;
	logic [AW-1:0]    base_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    way_q;
	logic [1:0]       status_q;
	logic [HW-1:0]    fh_q;

	logic             accept;
	logic [3:0]       len_in;
	logic [3:0]       len_sat;
	logic [MOD_W-1:0] modulus;
	hash_stat_t       hstat;

	logic             fill_we;
	logic [BW-1:0]    fill_waddr;
	logic [CW-1:0]    fill_wdata;
	logic [CW-1:0]    fill_rd;
	logic             ent_we;
	logic [AW-1:0]    ent_waddr;
	logic [AW-1:0]    ent_raddr;
	logic [KW+HW-1:0] ent_rd;
	logic [KW-1:0]    cmask;
	logic             match;
	logic             has_room;
	logic             last_way;
	logic             out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == S_IDLE;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_fh_q;
	assign m_tuser   = out_status_q;
	assign out_free  = !out_v_q || m_tready;

	assign len_in  = s_tdata[67:64];
	assign len_sat = len_in > 4'(KEY_BYTES) ? 4'(KEY_BYTES) : len_in;
	assign modulus = (bc_q == '0) ? MOD_W'(1) : ((bc_q > 7'(MMAX)) ? 7'(MMAX) : bc_q);

	bht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata[KW-1:0]),
		.len    (len_sat),
		.modulus(modulus),
		.stat   (hstat)
	);

	assign has_room   = fill_rd < CW'(WAYS);
	assign fill_we    = (state_q == S_CLEAR) ||
		(state_q == S_CHK && op_q == OP_INSERT && has_room);
	assign fill_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
	assign fill_wdata = (state_q == S_CLEAR) ? '0 : fill_rd + CW'(1);

	bht_ram #(.W(CW), .D(BUCKETS)) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.raddr(bucket_q),
		.rdata(fill_rd)
	);

	assign ent_we    = state_q == S_CHK && op_q == OP_INSERT && has_room;
	assign ent_waddr = base_q + AW'(fill_rd);
	assign ent_raddr = (state_q == S_CHK) ? base_q : base_q + AW'(way_q) + AW'(1);

	bht_ram #(.W(KW + HW), .D(SLOTS)) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata({hdl_q, key_q}),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			cmask[8*i +: 8] = {8{4'(i) < len_q}};
		end
	end

	assign match    = ((ent_rd[KW-1:0] ^ key_q) & cmask) == '0;
	assign last_way = (way_q + CW'(1)) >= cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			bc_q    <= 7'd64;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bc_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hstat.done) begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (op_q == OP_INSERT || fill_rd == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match || last_way) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			out_fh_q     <= 16'(fh_q);
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= s_tuser[0];
					key_q <= s_tdata[KW-1:0];
					len_q <= len_sat;
					hdl_q <= s_tdata[68 +: HW];
				end
			end
			S_HASH: begin
				if (hstat.done) begin
					bucket_q <= BW'(hstat.rem);
				end
			end
			S_FRD: begin
				base_q <= AW'(bucket_q) * AW'(WAYS);
			end
			S_CHK: begin
				cnt_q <= fill_rd;
				way_q <= '0;
				fh_q  <= '0;
				if (op_q == OP_INSERT) begin
					status_q <= has_room ? ST_DONE : ST_FULL;
				end else begin
					status_q <= ST_MISS;
				end
			end
			S_SCAN: begin
				if (match) begin
					status_q <= ST_DONE;
					fh_q     <= ent_rd[KW +: HW];
				end else if (!last_way) begin
					way_q <= way_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/bht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bht_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                    wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                    rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/bht_hash.sv @@
// Byte-sum hash with a bit-serial compare-subtract remainder unit.
module bht_hash import bht_pkg::*; #(
	parameter int KEY_BYTES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [8*KEY_BYTES-1:0] key,
	input  logic [3:0]             len,
	input  logic [MOD_W-1:0]       modulus,
	output hash_stat_t             stat
);

	localparam int SUM_W = $clog2(255 * KEY_BYTES + 1);
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sh_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] m_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MOD_W:0]   trial;
	logic [MOD_W:0]   diff;
	logic             ge;

	always_comb begin
		sum = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (4'(i) < len) begin
				sum = sum + SUM_W'(key[8*i +: 8]);
			end
		end
	end

	assign trial = {rem_q, sh_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, m_q};
	assign diff  = trial - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= sum;
			rem_q <= '0;
			m_q   <= modulus;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
			sh_q  <= sh_q << 1;
		end
	end

	assign stat.done = cnt_q == '0;
	assign stat.rem  = rem_q;

endmodule

@@ rtl/core/bht_sva.sv @@
// Port-level checker for the bucketed hash table unit, with its bind.
`include "bucketed_hash_table_unit_assert.svh"

module bht_sva import bht_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`BHT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
	`BHT_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tuser == ST_DONE || m_tuser == ST_MISS || m_tuser == ST_FULL, "undefined status code")
	`BHT_ASSERT_NOW(a_miss_zero, clk, arst_n, m_tvalid && m_tuser != ST_DONE, m_tdata == 16'd0, "handle not zero on miss or full")
	`BHT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input ready right after accepting a word")

endmodule

bind bucketed_hash_table_unit bht_sva u_bht_sva (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ sim/bucketed_hash_table_unit_tb.sv @@
// Testbench for the bucketed hash table unit: directed table and random words checked against a behavioral table model.
module bucketed_hash_table_unit_tb;
	import bht_pkg::*;

	localparam int NBUCKETS = 64;
	localparam int NWAYS = 8;
	localparam int RUN_LIMIT = 400000;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 230;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found;
	} outcome_t;

	typedef struct {
		logic        op;
		logic [63:0] key;
		logic [3:0]  len;
		logic [15:0] hnd;
		bit          typed;
		outcome_t    res;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;    // key_bytes[63:0], key_len[67:64], handle[83:68], pad
	logic [0:0]  s_tuser;    // op
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // found_handle
	logic [1:0]  m_tuser;    // status

	logic [3:0]  bucket_fill [NBUCKETS];
	logic [63:0] slot_key [NBUCKETS*NWAYS];
	logic [15:0] slot_handle [NBUCKETS*NWAYS];
	logic [6:0]  modulus_reg;
	logic [6:0]  phase_mod [PHASES] = '{7'd64, 7'd127, 7'd37, 7'd0, 7'd13, 7'd1, 7'd64};

	outcome_t    pending_results [$];
	vector_t     directed_words [$];
	logic [63:0] known_key [$];
	logic [3:0]  known_len [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          idle_on = 1'b0;

	bucketed_hash_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [63:0] key_mask(input int n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	// Hash, insert or scan on the local copy of the table.
	function automatic outcome_t apply_table_op(input logic op, input logic [63:0] key,
			input logic [3:0] len_in, input logic [15:0] hnd);
		int n;
		int m;
		int sum;
		int b;
		int slot;
		outcome_t res;
		n = (len_in > 4'd8) ? 8 : int'(len_in);
		m = (modulus_reg == 7'd0) ? 1 : (modulus_reg > 7'd64) ? 64 : int'(modulus_reg);
		sum = 0;
		for (int i = 0; i < n; i++)
			sum += int'(key[8*i +: 8]);
		b = sum % m;
		res = '0;
		res.status = ST_DONE;
		if (op == OP_INSERT) begin
			if (bucket_fill[b] >= NWAYS) begin
				res.status = ST_FULL;
			end else begin
				slot = b * NWAYS + int'(bucket_fill[b]);
				slot_key[slot] = key;
				slot_handle[slot] = hnd;
				bucket_fill[b] = bucket_fill[b] + 4'd1;
			end
			return res;
		end
		for (int w = 0; w < int'(bucket_fill[b]); w++) begin
			if (((slot_key[b*NWAYS + w] ^ key) & key_mask(n)) == 64'd0) begin
				res.found = slot_handle[b*NWAYS + w];
				return res;
			end
		end
		res.status = ST_MISS;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < 200)
			$display("[%0t] %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_word(input logic op, input logic [63:0] key, input logic [3:0] len,
			input logic [15:0] hnd, input bit typed, input outcome_t typed_res);
		int gap;
		outcome_t res;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, hnd, len, key};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = apply_table_op(op, key, len, hnd);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// Only called with the block idle.
	task automatic write_modulus(input logic [6:0] v);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		modulus_reg = v;
	endtask

	initial begin : result_check
		int stall;
		outcome_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				@(posedge clk);
				while (!m_tvalid) @(posedge clk);
				repeat (stall - 1) @(posedge clk);
				m_tready <= 1'b1;
			end
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending", m_tdata, 16'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", {14'd0, m_tuser}, {14'd0, want.status});
				if (m_tdata !== want.found)
					report_mismatch("found_handle", m_tdata, want.found);
			end
		end
	end

	initial begin : stimulus
		logic        op;
		logic [63:0] key;
		logic [63:0] rnd;
		logic [3:0]  len;
		logic [15:0] hnd;
		int          roll;
		int          pick;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		modulus_reg = 7'd64;
		foreach (bucket_fill[i])
			bucket_fill[i] = 4'd0;

		// empty table, then bucket 0 filled to the brim; bucket count stays at reset value
		directed_words.push_back('{OP_LOOKUP, 64'h0, 4'd1, 16'h0, 1'b1, '{ST_MISS, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, '1, 4'd0, 16'h0, 1'b1, '{ST_MISS, 16'h0}});
		directed_words.push_back('{OP_INSERT, '1, 4'd8, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, '1, 4'd8, 16'h0, 1'b1, '{ST_DONE, 16'hFFFF}});
		directed_words.push_back('{OP_INSERT, 64'h0, 4'd1, 16'hA5A5, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'h1234_5678_9ABC_DEF0, 4'd0, 16'h0,
			1'b1, '{ST_DONE, 16'hA5A5}});
		directed_words.push_back('{OP_INSERT, 64'h40, 4'd1, 16'h1234, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'h40, 4'd1, 16'h0, 1'b0, '0});
		directed_words.push_back('{OP_INSERT, 64'h40, 4'd1, 16'h5678, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'hDEAD_BEEF_0000_0040, 4'd1, 16'hFFFF, 1'b0, '0});
		directed_words.push_back('{OP_INSERT, 64'h0807_0605_0403_0201, 4'd15, 16'h0F0F,
			1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'h0807_0605_0403_0201, 4'd8, 16'h0, 1'b0, '0});
		directed_words.push_back('{OP_LOOKUP, 64'h08, 4'd1, 16'h0, 1'b1, '{ST_MISS, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h80, 4'd1, 16'h0001, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'hC0, 4'd1, 16'h0002, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h4000, 4'd2, 16'h0003, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h8000, 4'd2, 16'h0004, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'hC000, 4'd2, 16'h0005, 1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h0, 4'd1, 16'h7777, 1'b1, '{ST_FULL, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'hC000, 4'd2, 16'h0, 1'b0, '0});
		directed_words.push_back('{OP_LOOKUP, 64'h4040, 4'd2, 16'h0, 1'b1, '{ST_MISS, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h55, 4'd0, 16'h1111, 1'b1, '{ST_FULL, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, 64'hFF, 4'd1, 16'h0, 1'b1, '{ST_MISS, 16'h0}});
		directed_words.push_back('{OP_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 4'd7, 16'h8001,
			1'b1, '{ST_DONE, 16'h0}});
		directed_words.push_back('{OP_LOOKUP, '1, 4'd7, 16'h0, 1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		foreach (directed_words[i])
			send_word(directed_words[i].op, directed_words[i].key, directed_words[i].len,
				directed_words[i].hnd, directed_words[i].typed, directed_words[i].res);

		for (int p = 0; p < PHASES; p++) begin
			write_modulus(phase_mod[p]);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k % 40 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				roll = $urandom_range(0, 99);
				rnd = {$urandom, $urandom};
				hnd = 16'($urandom_range(0, 65535));
				if ($urandom_range(0, 15) == 0)
					len = 4'($urandom_range(0, 15));
				else
					len = 4'($urandom_range(1, 8));
				if (roll < 6) begin
					op = 1'($urandom_range(0, 1));
					key = rnd;
				end else begin
					op = (roll < 46) ? OP_INSERT : OP_LOOKUP;
					key = rnd & key_mask(len);
					// reuse a stored key: mostly for lookups, sometimes as a duplicate insert
					if (known_key.size() != 0 && $urandom_range(0, 3) != 0 &&
							(op == OP_LOOKUP || $urandom_range(0, 3) == 0)) begin
						pick = $urandom_range(0, known_key.size() - 1);
						len = known_len[pick];
						key = known_key[pick];
						if ($urandom_range(0, 3) == 0)
							key = (key & key_mask(len)) | (rnd & ~key_mask(len));
					end
				end
				if (op == OP_INSERT) begin
					known_key.push_back(key);
					known_len.push_back(len);
				end
				send_word(op, key, len, hnd, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bht_pkg.sv
rtl/core/bht_ram.sv
rtl/core/bht_hash.sv
rtl/core/bucketed_hash_table_unit.sv
rtl/core/bht_sva.sv
sim/bucketed_hash_table_unit_tb.sv
